// ----- src/arrseq_pkg.sv -----
`default_nettype none

package arrseq_pkg;

    // Section codes, 4 bits
    typedef logic [3:0] t_section;

    localparam t_section SEC_STOPPED  = 4'd0;
    localparam t_section SEC_INTRO_A  = 4'd1;
    localparam t_section SEC_INTRO_C  = 4'd3;
    localparam t_section SEC_MAIN_A   = 4'd4;
    localparam t_section SEC_FILL_A   = 4'd8;
    localparam t_section SEC_BREAK    = 4'd12;
    localparam t_section SEC_ENDING_A = 4'd13;

    // Request type codes
    localparam logic [2:0] REQ_INTRO  = 3'd0;
    localparam logic [2:0] REQ_MAIN   = 3'd1;
    localparam logic [2:0] REQ_BREAK  = 3'd2;
    localparam logic [2:0] REQ_ENDING = 3'd3;
    localparam logic [2:0] REQ_STOP   = 3'd4;
    localparam logic [2:0] REQ_TICK   = 3'd5;

    // Button variations
    localparam logic [1:0] VAR_A = 2'd0;
    localparam logic [1:0] VAR_B = 2'd1;
    localparam logic [1:0] VAR_C = 2'd2;
    localparam logic [1:0] VAR_D = 2'd3;

    // Input word
    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] variation;
    } t_in_word;

    // Result word
    typedef struct packed {
        t_section current_section;
        t_section queued_section;
        t_section target_section;
        logic     section_changed;
    } t_out_word;

    // Sequencer state
    typedef struct packed {
        t_section playing;
        t_section pending;
        t_section target;
    } t_seq_state;

endpackage

`default_nettype wire

// ----- src/arrseq_step.sv -----
`default_nettype none

// Next-state logic for one request word
module arrseq_step (
    input  var arrseq_pkg::t_seq_state i_state,
    input  var arrseq_pkg::t_in_word   i_word,
    output arrseq_pkg::t_seq_state     o_state,
    output logic                       o_changed
);

    logic is_intro;
    logic is_transient;
    logic is_ending;
    logic var_abc;
    logic queue_move;

    // Section class decode of the playing section
    assign is_intro     = (i_state.playing >= arrseq_pkg::SEC_INTRO_A) &&
                          (i_state.playing <= arrseq_pkg::SEC_INTRO_C);
    assign is_transient = is_intro ||
                          ((i_state.playing >= arrseq_pkg::SEC_FILL_A) &&
                           (i_state.playing <= arrseq_pkg::SEC_BREAK));
    assign is_ending    = i_state.playing >= arrseq_pkg::SEC_ENDING_A;
    assign var_abc      = i_word.variation != arrseq_pkg::VAR_D;
    assign queue_move   = (i_state.pending != arrseq_pkg::SEC_STOPPED) &&
                          (i_state.pending != i_state.playing);

    // Request dispatch
    always_comb begin
        o_state   = i_state;
        o_changed = 1'b0;
        case (i_word.req_type)
            arrseq_pkg::REQ_INTRO: begin
                if (var_abc) begin
                    o_state.pending = arrseq_pkg::SEC_INTRO_A + {2'b00, i_word.variation};
                end
                o_state.target = arrseq_pkg::SEC_MAIN_A;
            end
            arrseq_pkg::REQ_MAIN: begin
                if (i_state.playing == arrseq_pkg::SEC_STOPPED || is_intro) begin
                    o_state.pending = arrseq_pkg::SEC_MAIN_A + {2'b00, i_word.variation};
                end else begin
                    o_state.pending = arrseq_pkg::SEC_FILL_A + {2'b00, i_word.variation};
                    o_state.target  = arrseq_pkg::SEC_MAIN_A + {2'b00, i_word.variation};
                end
            end
            arrseq_pkg::REQ_BREAK: begin
                o_state.pending = arrseq_pkg::SEC_BREAK;
                if (i_state.target == arrseq_pkg::SEC_STOPPED) begin
                    o_state.target = i_state.playing;
                end
            end
            arrseq_pkg::REQ_ENDING: begin
                if (var_abc) begin
                    o_state.pending = arrseq_pkg::SEC_ENDING_A + {2'b00, i_word.variation};
                end
                o_state.target = arrseq_pkg::SEC_STOPPED;
            end
            arrseq_pkg::REQ_STOP: begin
                o_state.playing = arrseq_pkg::SEC_STOPPED;
                o_state.pending = arrseq_pkg::SEC_STOPPED;
                o_state.target  = arrseq_pkg::SEC_STOPPED;
            end
            arrseq_pkg::REQ_TICK: begin
                // queued section wins, then transient drop, then ending stop
                if (queue_move) begin
                    o_state.playing = i_state.pending;
                    o_state.pending = arrseq_pkg::SEC_STOPPED;
                    o_changed       = 1'b1;
                end else if (is_transient) begin
                    o_state.playing = i_state.target;
                    o_changed       = 1'b1;
                end else if (is_ending) begin
                    o_state.playing = arrseq_pkg::SEC_STOPPED;
                    o_changed       = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/arranger_section_sequencer_unit.sv -----
// Arranger section sequencer.
// Input channel: i_in_valid / o_in_stall carry one request word (button event
// with variation, or measure-boundary tick). Output channel: o_out_valid /
// i_out_stall carry one result word per request: current, queued and target
// section codes plus a flag for a section change on a tick.
// A word is taken when valid is high and stall is low at a rising edge.
// A taken request is held in the input register, then its result is loaded
// into the result register; the section state registers update on the same
// edge that loads the result register.
// Throughput: one word per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its word, the input
// register fills, and o_in_stall rises until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers and returns all
// three sections to stopped.
`default_nettype none

module arranger_section_sequencer_unit (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    input  var logic                  i_in_valid,
    output logic                      o_in_stall,
    input  var arrseq_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  var logic                  i_out_stall,
    output arrseq_pkg::t_out_word     o_out_word
);

    logic                   r_in_valid;
    arrseq_pkg::t_in_word   r_in_word;
    logic                   r_out_valid;
    arrseq_pkg::t_out_word  r_out_word;
    arrseq_pkg::t_seq_state r_state;
    arrseq_pkg::t_seq_state n_state;
    logic                   n_changed;
    logic                   advance;

    // Next state for the word in the input register
    arrseq_step u_step (
        .i_state   (r_state),
        .i_word    (r_in_word),
        .o_state   (n_state),
        .o_changed (n_changed)
    );

    // Move a word forward when the result register is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Section state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{default: arrseq_pkg::SEC_STOPPED};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_word.current_section <= n_state.playing;
            r_out_word.queued_section  <= n_state.pending;
            r_out_word.target_section  <= n_state.target;
            r_out_word.section_changed <= n_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire
